### design/ssi_pkg.sv
`default_nettype none

package ssi_pkg;

  // Frame geometry.
  localparam int unsigned FRAME_BITS   = 33;
  localparam int unsigned NUM_CHANNELS = 6;
  localparam int unsigned MAX_CHANNELS = 6;
  localparam int unsigned EDGE_W       = $clog2(2 * FRAME_BITS + 1);
  localparam logic [EDGE_W-1:0] LAST_EDGE = EDGE_W'(2 * FRAME_BITS);

  // Register widths and reset values.
  localparam int unsigned HALF_W  = 16;
  localparam int unsigned REC_W   = 20;
  localparam int unsigned TYPES_W = 3 * MAX_CHANNELS;
  localparam int unsigned CFG_W   = 20;
  localparam logic [HALF_W-1:0]  HALF_RESET  = 16'd200;
  localparam logic [REC_W-1:0]   REC_RESET   = 20'd3000;
  localparam logic [REC_W-1:0]   REC_MAX     = 20'hFFFFF;

  // Configuration register indexes.
  localparam logic [1:0] CFG_HALF_PERIOD = 2'd0;
  localparam logic [1:0] CFG_RECOVERY    = 2'd1;
  localparam logic [1:0] CFG_TYPES       = 2'd2;

  // Channel type codes; unlisted codes decode as multi-turn.
  localparam logic [2:0] TYPE_MULTI25  = 3'd0;
  localparam logic [2:0] TYPE_SINGLE13 = 3'd1;
  localparam logic [2:0] TYPE_LINEAR28 = 3'd2;
  localparam logic [2:0] TYPE_GRAY13   = 3'd3;
  localparam logic [2:0] TYPE_GRAY16   = 3'd4;

  localparam int unsigned COUNT_W   = 25;
  localparam int unsigned LIN_SCALE = 1000;

  // Per-tick strobes from the sequencer to the lanes.
  typedef struct packed {
    logic clear;
    logic sample;
    logic decode;
  } seq_ctl_t;

  // One result item, packed so that ssi_clock lands in bit 0.
  typedef struct packed {
    logic [6:0]         pad;
    logic [17:0]        flag_bits;
    logic [5:0]         valid_mask;
    logic [COUNT_W-1:0] count_ch5;
    logic [COUNT_W-1:0] count_ch4;
    logic [COUNT_W-1:0] count_ch3;
    logic [COUNT_W-1:0] count_ch2;
    logic [COUNT_W-1:0] count_ch1;
    logic [COUNT_W-1:0] count_ch0;
    logic               done_res;
    logic               busy_res;
    logic               ssi_clock;
  } result_t;

  // Gray to binary for words of up to 16 bits.
  function automatic logic [15:0] gray_to_bin(input logic [15:0] g);
    logic [15:0] b;
    for (int i = 0; i < 16; i++) begin
      b[i] = ^(g >> i);
    end
    return b;
  endfunction

endpackage

`default_nettype wire

### design/ssi_encoder_master_decoder_core.sv
// SSI master for six absolute encoders on one shared clock line.
// Each input item is one system tick: s_tdata_i carries the start request
// and the sampled data line of every channel. For each input item the block
// returns one result item with the clock line level, busy and done flags and
// the decoded count, valid bit and flags of each channel.
// Each result is registered in the output register, or first in the skid
// register under a stall. Throughput is one item per cycle while m_tready_i
// is high. The tick step, the frame sequencer and all six decode lanes sit
// in a single register stage, with the linear decode multiplier as the longest path.
// An output register plus a one-item skid register part the two channels:
// when m_tready_i is low, one more input item is taken into the skid
// register and s_tready_o then drops until the result register drains.
// Configuration is written through cfg_we_i, cfg_index_i and cfg_data_i
// (0 half period, 1 recovery gap, 2 channel types) and acts at once.
// Reset returns the registers to their defaults, clears the frame and the
// decoded values, and starts the recovery count from zero, so the first read
// waits the recovery gap after reset.
`default_nettype none

module ssi_encoder_master_decoder_core
  import ssi_pkg::*;
(
  input  wire           clk_i,
  input  wire           rst_ni,
  // Input item: bit 0 start_req, bits 6:1 data_lines, bit 7 zero.
  input  wire  [7:0]    s_tdata_i,
  input  wire           s_tvalid_i,
  output logic          s_tready_o,
  // Result item: ssi_clock, busy_res, done_res, count_ch0..count_ch5,
  // valid_mask, flag_bits from bit 0 up, zero-filled to 184 bits.
  output logic [183:0]  m_tdata_o,
  output logic          m_tvalid_o,
  input  wire           m_tready_i,
  input  wire           cfg_we_i,
  input  wire  [1:0]    cfg_index_i,
  input  wire  [CFG_W-1:0] cfg_data_i
);

  logic [HALF_W-1:0]  half_q;
  logic [REC_W-1:0]   rec_cfg_q;
  logic [TYPES_W-1:0] types_q;

  logic      in_acc, out_acc;
  seq_ctl_t  ctl;
  logic      ssi_clock, busy;

  logic [COUNT_W-1:0] count [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] valid;
  logic [TYPES_W-1:0]      flags;

  result_t res;
  result_t out_q, skid_q;
  logic    out_valid_q, skid_valid_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q    <= HALF_RESET;
      rec_cfg_q <= REC_RESET;
      types_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_HALF_PERIOD: half_q    <= cfg_data_i[HALF_W-1:0];
        CFG_RECOVERY:    rec_cfg_q <= cfg_data_i[REC_W-1:0];
        CFG_TYPES:       types_q   <= cfg_data_i[TYPES_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_tready_o = ~skid_valid_q;
  assign in_acc     = s_tvalid_i & s_tready_o;
  assign out_acc    = m_tvalid_o & m_tready_i;

  ssi_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (in_acc),
    .start_req_i   (s_tdata_i[0]),
    .half_period_i (half_q),
    .recovery_i    (rec_cfg_q),
    .ctl_o         (ctl),
    .ssi_clock_o   (ssi_clock),
    .busy_o        (busy)
  );

  // One decode lane per connected channel.
  for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_lane
    ssi_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .line_i  (s_tdata_i[1+i]),
      .type_i  (types_q[3*i +: 3]),
      .count_o (count[i]),
      .valid_o (valid[i]),
      .flags_o (flags[3*i +: 3])
    );
  end

  // Channels beyond the connected ones read as zero.
  for (genvar i = NUM_CHANNELS; i < MAX_CHANNELS; i++) begin : g_unused
    assign count[i]        = '0;
    assign valid[i]        = 1'b0;
    assign flags[3*i +: 3] = '0;
  end

  // Merge the lanes and the sequencer into one result item.
  always_comb begin
    res            = '0;
    res.ssi_clock  = ssi_clock;
    res.busy_res   = busy;
    res.done_res   = ctl.decode;
    res.count_ch0  = count[0];
    res.count_ch1  = count[1];
    res.count_ch2  = count[2];
    res.count_ch3  = count[3];
    res.count_ch4  = count[4];
    res.count_ch5  = count[5];
    res.valid_mask = valid;
    res.flag_bits  = flags;
  end

  // Result register with a one-item skid stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_acc || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_acc || !out_valid_q) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_acc) begin
        out_q <= res;
      end
    end else if (in_acc) begin
      skid_q <= res;
    end
  end

  assign m_tdata_o  = out_q;
  assign m_tvalid_o = out_valid_q;

  // The skid stage only holds an item behind a full result register.
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid item without a result item ahead of it");

  // The skid stage fills only while the result register is stalled.
  a_skid_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !m_tready_i))
    else $error("skid stage filled without a stall");

  // A finished read leaves the line idle high and the block not busy.
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && ctl.decode) |-> (ssi_clock && !busy))
    else $error("read completed with the line or busy flag active");

endmodule

`default_nettype wire

### design/ssi_seq.sv
`default_nettype none

module ssi_seq
  import ssi_pkg::*;
(
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 step_i,
  input  wire                 start_req_i,
  input  wire  [HALF_W-1:0]   half_period_i,
  input  wire  [REC_W-1:0]    recovery_i,
  output seq_ctl_t            ctl_o,
  output logic                ssi_clock_o,
  output logic                busy_o
);

  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_CAL_LOW  = 2'd1;
  localparam logic [1:0] PH_CAL_HIGH = 2'd2;
  localparam logic [1:0] PH_CLOCKING = 2'd3;

  logic [1:0]        phase_q, phase_d;
  logic [HALF_W-1:0] half_q, half_d;
  logic [EDGE_W-1:0] edge_q, edge_d;
  logic [REC_W-1:0]  rec_q, rec_d;
  logic              pend_q, pend_d;

  logic [HALF_W-1:0] hp;
  logic [HALF_W:0]   half_inc;
  logic              half_end;
  logic [EDGE_W-1:0] edge_inc;

  // A zero half period behaves as one tick.
  assign hp       = (half_period_i == '0) ? HALF_W'(1) : half_period_i;
  assign half_inc = {1'b0, half_q} + (HALF_W+1)'(1);
  assign half_end = half_inc >= {1'b0, hp};
  assign edge_inc = edge_q + EDGE_W'(1);

  // Next state for one tick.
  always_comb begin
    phase_d = phase_q;
    half_d  = half_q;
    edge_d  = edge_q;
    rec_d   = rec_q;
    pend_d  = pend_q;
    ctl_o   = '0;
    if (step_i) begin
      pend_d = pend_q | start_req_i;
      case (phase_q)
        PH_IDLE: begin
          if (pend_d && (rec_q >= recovery_i)) begin
            phase_d   = PH_CAL_LOW;
            half_d    = '0;
            ctl_o.clear = 1'b1;
          end else if (rec_q < REC_MAX) begin
            rec_d = rec_q + REC_W'(1);
          end
        end
        PH_CAL_LOW: begin
          if (half_end) begin
            half_d  = '0;
            phase_d = PH_CAL_HIGH;
          end else begin
            half_d = half_inc[HALF_W-1:0];
          end
        end
        PH_CAL_HIGH: begin
          if (half_end) begin
            half_d       = '0;
            edge_d       = '0;
            phase_d      = PH_CLOCKING;
            ctl_o.sample = 1'b1;
          end else begin
            half_d = half_inc[HALF_W-1:0];
          end
        end
        default: begin
          if (half_end) begin
            half_d = '0;
            if (edge_inc >= LAST_EDGE) begin
              ctl_o.decode = 1'b1;
              edge_d       = '0;
              phase_d      = PH_IDLE;
              rec_d        = '0;
              pend_d       = 1'b0;
            end else begin
              edge_d       = edge_inc;
              ctl_o.sample = ~edge_inc[0];
            end
          end else begin
            half_d = half_inc[HALF_W-1:0];
          end
        end
      endcase
    end
  end

  // Line levels after the tick.
  always_comb begin
    case (phase_d)
      PH_IDLE, PH_CAL_HIGH: ssi_clock_o = 1'b1;
      PH_CAL_LOW:           ssi_clock_o = 1'b0;
      default:              ssi_clock_o = edge_d[0];
    endcase
  end
  assign busy_o = (phase_d != PH_IDLE) || pend_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      half_q  <= '0;
      edge_q  <= '0;
      rec_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      half_q  <= half_d;
      edge_q  <= edge_d;
      rec_q   <= rec_d;
      pend_q  <= pend_d;
    end
  end

endmodule

`default_nettype wire

### design/ssi_lane.sv
`default_nettype none

module ssi_lane
  import ssi_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire seq_ctl_t        ctl_i,
  input  wire                  line_i,
  input  wire  [2:0]           type_i,
  output logic [COUNT_W-1:0]   count_o,
  output logic                 valid_o,
  output logic [2:0]           flags_o
);

  logic [FRAME_BITS-1:0] shift_q, shift_d;
  logic [COUNT_W-1:0]    count_q, count_new;
  logic                  valid_q, valid_new;
  logic [2:0]            flags_q, flags_new;

  logic [24:0] w25;
  logic [12:0] w13;
  logic [15:0] w16;
  logic [27:0] w28;
  logic [COUNT_W-1:0] lin_prod;

  // Frame shift register, MSB first.
  always_comb begin
    shift_d = shift_q;
    if (ctl_i.clear) begin
      shift_d = '0;
    end else if (ctl_i.sample) begin
      shift_d = {shift_q[FRAME_BITS-2:0], line_i};
    end
  end

  // Words sit at the top of the frame; the bit below each is its end marker.
  assign w25 = shift_q[FRAME_BITS-1 -: 25];
  assign w13 = shift_q[FRAME_BITS-1 -: 13];
  assign w16 = shift_q[FRAME_BITS-1 -: 16];
  assign w28 = shift_q[FRAME_BITS-1 -: 28];
  assign lin_prod = COUNT_W'(w28[27:13]) * COUNT_W'(LIN_SCALE);

  // Decode by channel type.
  always_comb begin
    flags_new = '0;
    case (type_i)
      TYPE_SINGLE13: begin
        count_new = COUNT_W'(w13);
        valid_new = ~shift_q[FRAME_BITS-14];
      end
      TYPE_GRAY13: begin
        count_new = COUNT_W'(gray_to_bin({3'b000, w13}));
        valid_new = ~shift_q[FRAME_BITS-14];
      end
      TYPE_GRAY16: begin
        count_new = COUNT_W'(gray_to_bin(w16));
        valid_new = ~shift_q[FRAME_BITS-17];
      end
      TYPE_LINEAR28: begin
        count_new = lin_prod + COUNT_W'(w28[12:3]);
        valid_new = ~shift_q[FRAME_BITS-29];
        flags_new = {^w28, w28[1:0]};
      end
      default: begin
        count_new = w25;
        valid_new = ~shift_q[FRAME_BITS-26];
      end
    endcase
  end

  // Results follow the decode strobe within the same tick.
  assign count_o = ctl_i.decode ? count_new : count_q;
  assign valid_o = ctl_i.decode ? valid_new : valid_q;
  assign flags_o = ctl_i.decode ? flags_new : flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
      count_q <= '0;
      valid_q <= 1'b0;
      flags_q <= '0;
    end else begin
      shift_q <= shift_d;
      count_q <= count_o;
      valid_q <= valid_o;
      flags_q <= flags_o;
    end
  end

endmodule

`default_nettype wire
